// ===== rtl/core/gic_pkg.sv =====
// Shared types, constants and helper functions for the gamepad input conditioner.
// Depends on nothing; imported by gamepad_input_conditioner_top.
`default_nettype none
package gic_pkg;

   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes on the csr port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LT_THRESHOLD = 3'd0,
      CSR_RT_THRESHOLD = 3'd1,
      CSR_LS_DEADZONE  = 3'd2,
      CSR_RS_DEADZONE  = 3'd3,
      CSR_GYRO_DEADZONE = 3'd4,
      CSR_GYRO_SENS    = 3'd5,
      CSR_GYRO_HOTKEY  = 3'd6,
      CSR_MODE_FLAGS   = 3'd7
   } csr_index_type;

   // Bit positions in buttons and mode_flags
   localparam int BTN_TOUCH   = 0;
   localparam int BTN_OPTIONS = 1;
   localparam int BTN_SHARE   = 2;

   localparam int MODE_GYRO_STICK   = 0;
   localparam int MODE_TRIG_BUTTONS = 1;
   localparam int MODE_TOUCH_START  = 2;
   localparam int MODE_TOUCH_SELECT = 3;
   localparam int MODE_SHARE_SELECT = 4;

   localparam logic [7:0]         CENTER       = 8'd128;
   localparam logic [7:0]         GYRO_LO      = 8'd48;   // center - 80
   localparam logic [7:0]         GYRO_HI      = 8'd208;  // center + 80
   localparam logic [11:0]        TOUCH_SPLIT  = 12'd1000;
   localparam logic signed [31:0] GYRO_FULL    = 32'sd256000;
   localparam logic [15:0]        GYRO_SENS_RESET = 16'd256;
   // floor(n / 125) for n < 2^15 as (n * RECIP_125) >> 22
   localparam logic [15:0]        RECIP_125    = 16'd33555;

   // Request item, last field in the lowest bits
   typedef struct packed {
      logic [5:0]         pad;
      logic [11:0]        touch1_x;
      logic [11:0]        touch0_x;
      logic [1:0]         touch_lifted;
      logic signed [15:0] gyro_z;
      logic signed [15:0] gyro_x;
      logic [7:0]         right_y_in;
      logic [7:0]         right_x_in;
      logic [7:0]         left_y_in;
      logic [7:0]         left_x_in;
      logic [7:0]         right_trigger_in;
      logic [7:0]         left_trigger_in;
      logic [15:0]        buttons_in;
   } req_type;

   // Result item, last field in the lowest bits
   typedef struct packed {
      logic [7:0]  right_y_out;
      logic [7:0]  right_x_out;
      logic [7:0]  left_y_out;
      logic [7:0]  left_x_out;
      logic [7:0]  right_trigger_out;
      logic [7:0]  left_trigger_out;
      logic [15:0] buttons_out;
   } rsp_type;

   // Stage 1: squared stick radii and raw gyro products
   typedef struct packed {
      logic [15:0]        buttons;
      logic [7:0]         ltrig;
      logic [7:0]         rtrig;
      logic [7:0]         lx;
      logic [7:0]         ly;
      logic [7:0]         rx;
      logic [7:0]         ry;
      logic [16:0]        lsum;
      logic [16:0]        rsum;
      logic signed [31:0] px;     // gyro_z * sensitivity
      logic signed [31:0] py;     // gyro_x * sensitivity
      logic               gyro_req;
   } s1_type;

   // Stage 2: deadzoned sticks and scaled gyro numerators
   typedef struct packed {
      logic [15:0] buttons;
      logic [7:0]  ltrig;
      logic [7:0]  rtrig;
      logic [7:0]  lx;
      logic [7:0]  ly;
      logic [7:0]  rx;
      logic [7:0]  ry;
      logic [14:0] nx;
      logic [14:0] ny;
      logic        gyro_req;
   } s2_type;

   // Stage 3: gyro stick position and select
   typedef struct packed {
      logic [15:0] buttons;
      logic [7:0]  ltrig;
      logic [7:0]  rtrig;
      logic [7:0]  lx;
      logic [7:0]  ly;
      logic [7:0]  rx;
      logic [7:0]  ry;
      logic [7:0]  gx;
      logic [7:0]  gy;
      logic        gyro_on;
   } s3_type;

   // Distance of a stick axis from center
   function automatic logic [7:0] axis_dist(input logic [7:0] v);
      axis_dist = (v >= CENTER) ? (v - CENTER) : (CENTER - v);
   endfunction

   // Squared radius of a stick position
   function automatic logic [16:0] radius_sq(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] dx;
      logic [7:0] dy;
      dx = axis_dist(x);
      dy = axis_dist(y);
      radius_sq = 17'(16'(dx) * 16'(dx)) + 17'(16'(dy) * 16'(dy));
   endfunction

   // Stick survives the deadzone when off or strictly outside the circle
   function automatic logic dz_keep(input logic [16:0] sum, input logic [7:0] dz);
      logic [15:0] dz_sq;
      dz_sq = 16'(dz) * 16'(dz);
      dz_keep = (dz == 8'd0) || (sum > {1'b0, dz_sq});
   endfunction

   // Clamp, invert and scale by 255, then divide by 4096 (the power-of-two part of the span)
   function automatic logic [14:0] gyro_num(input logic signed [31:0] p);
      logic signed [31:0] c;
      logic [18:0]        v;
      logic [26:0]        num;
      if (p > GYRO_FULL) begin
         c = GYRO_FULL;
      end else if (p < -GYRO_FULL) begin
         c = -GYRO_FULL;
      end else begin
         c = p;
      end
      v = 19'(GYRO_FULL - c);
      num = {v, 8'd0} - {8'd0, v};
      gyro_num = num[26:12];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gamepad_input_conditioner_top.sv =====
// Gamepad input conditioner: four-stage pipeline plus configuration registers.
// Depends on gic_pkg.
//
// Usage:
//   req_* carries one raw gamepad sample per item; rsp_* returns the conditioned
//   sample (remapped buttons, thresholded triggers, deadzoned sticks, optional
//   gyro-driven right stick). Every request item yields exactly one result item.
//   csr_* writes the eight configuration registers, one per cycle, no read-back;
//   write them only while no item is in flight.
// Timing:
//   An accepted item reaches rsp_tvalid through the stage registers (stage 1 squares and
//   products, stage 2 deadzones and gyro scaling, stage 3 reciprocal divide by
//   125 and gyro select, stage 4 gyro deadzone into the output register).
//   One item per cycle is sustained while rsp_tready stays high; the reciprocal
//   multiplier and the squaring stages set the stage depth.
// Reset and stall:
//   Reset empties the pipeline and loads register defaults (sensitivity 256,
//   all else 0). When rsp_tready is low the output register holds; bubbles in
//   earlier stages still fill, and req_tready drops once every stage is full.
`default_nettype none
module gamepad_input_conditioner_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   // buttons_in, left_trigger_in, right_trigger_in, left_x_in, left_y_in,
   // right_x_in, right_y_in, gyro_x, gyro_z, touch_lifted, touch0_x, touch1_x, zero pad
   input  wire logic [gic_pkg::REQ_DATA_W-1:0] req_tdata,
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // buttons_out, left_trigger_out, right_trigger_out, left_x_out, left_y_out,
   // right_x_out, right_y_out
   output      logic [gic_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                           csr_wen,
   input  wire logic [gic_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [gic_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gic_pkg::*;

   // Configuration registers
   logic [7:0]  lt_thr_ff, rt_thr_ff, ls_dz_ff, rs_dz_ff, gyro_dz_ff;
   logic [15:0] gyro_sens_ff, gyro_mask_ff;
   logic [4:0]  mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_thr_ff    <= '0;
         rt_thr_ff    <= '0;
         ls_dz_ff     <= '0;
         rs_dz_ff     <= '0;
         gyro_dz_ff   <= '0;
         gyro_sens_ff <= GYRO_SENS_RESET;
         gyro_mask_ff <= '0;
         mode_ff      <= '0;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_addr))
            CSR_LT_THRESHOLD:  lt_thr_ff    <= csr_wdata[7:0];
            CSR_RT_THRESHOLD:  rt_thr_ff    <= csr_wdata[7:0];
            CSR_LS_DEADZONE:   ls_dz_ff     <= csr_wdata[7:0];
            CSR_RS_DEADZONE:   rs_dz_ff     <= csr_wdata[7:0];
            CSR_GYRO_DEADZONE: gyro_dz_ff   <= csr_wdata[7:0];
            CSR_GYRO_SENS:     gyro_sens_ff <= csr_wdata;
            CSR_GYRO_HOTKEY:   gyro_mask_ff <= csr_wdata;
            CSR_MODE_FLAGS:    mode_ff      <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Pipeline valids and ready chain
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !s4_valid_ff || rsp_tready;
   assign rdy3 = !s3_valid_ff || rdy4;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;
   assign req_tready = rdy1;

   assign s1_valid_in = rdy1 ? req_tvalid  : s1_valid_ff;
   assign s2_valid_in = rdy2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = rdy3 ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = rdy4 ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   // Stage 1: buttons, triggers, squared radii, gyro products
   req_type req;
   s1_type  s1_ff, s1_in;
   logic    up0, up1, as_start, as_select, right_side, left_side;
   logic [15:0] b;
   logic signed [31:0] gz_ext, gx_ext, sens_ext;

   assign req = req_type'(req_tdata);

   always_comb begin
      up0       = req.touch_lifted[0];
      up1       = req.touch_lifted[1];
      as_start  = mode_ff[MODE_TOUCH_START];
      as_select = mode_ff[MODE_TOUCH_SELECT];
      right_side = (!up0 && req.touch0_x >= TOUCH_SPLIT) ||
                   (up0 && !up1 && req.touch1_x >= TOUCH_SPLIT);
      left_side  = (!up0 && req.touch0_x <= TOUCH_SPLIT) ||
                   (up0 && !up1 && req.touch1_x <= TOUCH_SPLIT);

      b = req.buttons_in;
      if (as_start && b[BTN_TOUCH] && (right_side || !as_select)) begin
         b[BTN_OPTIONS] = 1'b1;
         b[BTN_TOUCH]   = 1'b0;
      end
      if (!as_select && b[BTN_TOUCH] && (left_side || !as_start)) begin
         b[BTN_TOUCH] = 1'b0;
      end
      if (mode_ff[MODE_SHARE_SELECT] && b[BTN_SHARE]) begin
         b[BTN_TOUCH] = 1'b1;
         b[BTN_SHARE] = 1'b0;
      end

      s1_in.buttons = b;
      s1_in.ltrig = (req.left_trigger_in < lt_thr_ff) ? 8'd0 : req.left_trigger_in;
      s1_in.rtrig = (req.right_trigger_in < rt_thr_ff) ? 8'd0 : req.right_trigger_in;
      if (mode_ff[MODE_TRIG_BUTTONS]) begin
         s1_in.ltrig = (s1_in.ltrig != 8'd0) ? 8'd255 : 8'd0;
         s1_in.rtrig = (s1_in.rtrig != 8'd0) ? 8'd255 : 8'd0;
      end

      s1_in.lx   = req.left_x_in;
      s1_in.ly   = req.left_y_in;
      s1_in.rx   = req.right_x_in;
      s1_in.ry   = req.right_y_in;
      s1_in.lsum = radius_sq(req.left_x_in, req.left_y_in);
      s1_in.rsum = radius_sq(req.right_x_in, req.right_y_in);

      gz_ext   = 32'(req.gyro_z);
      gx_ext   = 32'(req.gyro_x);
      sens_ext = {16'd0, gyro_sens_ff};
      s1_in.px = gz_ext * sens_ext;
      s1_in.py = gx_ext * sens_ext;

      s1_in.gyro_req = mode_ff[MODE_GYRO_STICK] &&
                       ((req.buttons_in & gyro_mask_ff) == gyro_mask_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= s1_in;
      end
   end

   // Stage 2: stick deadzones, gyro clamp and scale
   s2_type s2_ff, s2_in;
   logic   lkeep, rkeep;

   always_comb begin
      lkeep = dz_keep(s1_ff.lsum, ls_dz_ff);
      rkeep = dz_keep(s1_ff.rsum, rs_dz_ff);
      s2_in.buttons  = s1_ff.buttons;
      s2_in.ltrig    = s1_ff.ltrig;
      s2_in.rtrig    = s1_ff.rtrig;
      s2_in.lx       = lkeep ? s1_ff.lx : CENTER;
      s2_in.ly       = lkeep ? s1_ff.ly : CENTER;
      s2_in.rx       = rkeep ? s1_ff.rx : CENTER;
      s2_in.ry       = rkeep ? s1_ff.ry : CENTER;
      s2_in.nx       = gyro_num(s1_ff.px);
      s2_in.ny       = gyro_num(s1_ff.py);
      s2_in.gyro_req = s1_ff.gyro_req;
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_ff <= s2_in;
      end
   end

   // Stage 3: divide by 125 through the reciprocal, window check
   s3_type s3_ff, s3_in;
   logic [30:0] qx_prod, qy_prod;

   always_comb begin
      qx_prod = 31'(s2_ff.nx) * 31'(RECIP_125);
      qy_prod = 31'(s2_ff.ny) * 31'(RECIP_125);
      s3_in.buttons = s2_ff.buttons;
      s3_in.ltrig   = s2_ff.ltrig;
      s3_in.rtrig   = s2_ff.rtrig;
      s3_in.lx      = s2_ff.lx;
      s3_in.ly      = s2_ff.ly;
      s3_in.rx      = s2_ff.rx;
      s3_in.ry      = s2_ff.ry;
      s3_in.gx      = qx_prod[29:22];
      s3_in.gy      = qy_prod[29:22];
      s3_in.gyro_on = s2_ff.gyro_req &&
                      (s2_ff.rx >= GYRO_LO) && (s2_ff.rx <= GYRO_HI) &&
                      (s2_ff.ry >= GYRO_LO) && (s2_ff.ry <= GYRO_HI);
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_ff <= s3_in;
      end
   end

   // Stage 4: gyro deadzone and right stick select into the output register
   rsp_type rsp_ff, rsp_in;
   logic    gkeep;

   always_comb begin
      gkeep = dz_keep(radius_sq(s3_ff.gx, s3_ff.gy), gyro_dz_ff);
      rsp_in.buttons_out       = s3_ff.buttons;
      rsp_in.left_trigger_out  = s3_ff.ltrig;
      rsp_in.right_trigger_out = s3_ff.rtrig;
      rsp_in.left_x_out        = s3_ff.lx;
      rsp_in.left_y_out        = s3_ff.ly;
      if (s3_ff.gyro_on) begin
         rsp_in.right_x_out = gkeep ? s3_ff.gx : CENTER;
         rsp_in.right_y_out = gkeep ? s3_ff.gy : CENTER;
      end else begin
         rsp_in.right_x_out = s3_ff.rx;
         rsp_in.right_y_out = s3_ff.ry;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = s4_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);

   // An empty output register never blocks the input side
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output register");

   // An accepted item always lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("accepted item lost at stage 1");

   // A blocked stage 3 item stays put
   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !rdy3) |=> (s3_valid_ff && $stable(s3_ff)))
      else $error("stage 3 item dropped or changed while blocked");

   // Nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result presented after reset");

endmodule
`default_nettype wire

// ===== sim/gamepad_input_conditioner_top_tb.sv =====
// Self-checking testbench for the gamepad input conditioner: directed corner
// samples, then random samples under several register settings with stalls.
// Depends on gic_pkg and gamepad_input_conditioner_top.
`timescale 1ns / 100ps

module gamepad_input_conditioner_top_tb;
   import gic_pkg::*;

   localparam int          STICK_CENTRE   = 128;
   localparam int          GYRO_REACH     = 80;
   localparam int          TOUCH_SPLIT_X  = 1000;
   localparam longint      GYRO_CLAMP     = 256000;
   localparam longint      GYRO_SPAN      = 512000;
   localparam int          DRAIN_CYCLES   = 10;
   localparam int          RANDOM_PHASES  = 8;
   localparam int          ITEMS_PER_PHASE = 230;
   localparam int          REPORT_LIMIT   = 200;
   localparam logic [15:0] TOUCH_MASK     = 16'd1 << BTN_TOUCH;
   localparam logic [15:0] SHARE_MASK     = 16'd1 << BTN_SHARE;
   localparam logic [15:0] HOTKEY_BIT     = 16'h8000;
   localparam logic [15:0] ALL_MODES      = 16'h001F;

   typedef struct {
      logic [7:0]  lt_threshold;
      logic [7:0]  rt_threshold;
      logic [7:0]  ls_deadzone;
      logic [7:0]  rs_deadzone;
      logic [7:0]  gyro_deadzone;
      logic [15:0] sens;
      logic [15:0] hotkey;
      logic [4:0]  mode;
   } cond_settings_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cond_settings_type cfg;
   req_type pending_samples[$];
   rsp_type expected_conditioned[$];
   bit  item_taken = 1'b0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  rsp_hold_cycles = 0;
   int  mismatch_count = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  settings_count = 0;

   gamepad_input_conditioner_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(2_000_000);
      $display("Timeout with %0d results still outstanding", expected_conditioned.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit stick_kept(int x, int y, int dz);
      return dz == 0 ||
         (x - STICK_CENTRE) * (x - STICK_CENTRE) + (y - STICK_CENTRE) * (y - STICK_CENTRE)
         > dz * dz;
   endfunction

   function automatic int gyro_to_axis(logic signed [15:0] g);
      longint p;
      p = longint'(g) * longint'(cfg.sens);
      if (p > GYRO_CLAMP) p = GYRO_CLAMP;
      if (p < -GYRO_CLAMP) p = -GYRO_CLAMP;
      return int'(((GYRO_CLAMP - p) * 255) / GYRO_SPAN);
   endfunction

   function automatic rsp_type condition_sample(req_type s);
      rsp_type     r;
      logic [15:0] b;
      int          lt, rt, lx, ly, rx, ry;
      bit          up0, up1, as_start, as_select;
      b = s.buttons_in;
      lt = s.left_trigger_in;
      rt = s.right_trigger_in;
      lx = s.left_x_in;
      ly = s.left_y_in;
      rx = s.right_x_in;
      ry = s.right_y_in;
      up0 = s.touch_lifted[0];
      up1 = s.touch_lifted[1];
      as_start = cfg.mode[MODE_TOUCH_START];
      as_select = cfg.mode[MODE_TOUCH_SELECT];

      if (lt < cfg.lt_threshold) lt = 0;
      if (rt < cfg.rt_threshold) rt = 0;
      if (!stick_kept(lx, ly, cfg.ls_deadzone)) begin
         lx = STICK_CENTRE;
         ly = STICK_CENTRE;
      end
      if (!stick_kept(rx, ry, cfg.rs_deadzone)) begin
         rx = STICK_CENTRE;
         ry = STICK_CENTRE;
      end

      if (cfg.mode[MODE_GYRO_STICK] && (b & cfg.hotkey) == cfg.hotkey &&
          rx - STICK_CENTRE <= GYRO_REACH && STICK_CENTRE - rx <= GYRO_REACH &&
          ry - STICK_CENTRE <= GYRO_REACH && STICK_CENTRE - ry <= GYRO_REACH) begin
         rx = gyro_to_axis(s.gyro_z);
         ry = gyro_to_axis(s.gyro_x);
         if (!stick_kept(rx, ry, cfg.gyro_deadzone)) begin
            rx = STICK_CENTRE;
            ry = STICK_CENTRE;
         end
      end

      if (cfg.mode[MODE_TRIG_BUTTONS]) begin
         lt = (lt != 0) ? 255 : 0;
         rt = (rt != 0) ? 255 : 0;
      end

      // right half of the pad acts as start, left half as select
      if (as_start && b[BTN_TOUCH]) begin
         if ((!up0 && s.touch0_x >= TOUCH_SPLIT_X) ||
             (up0 && !up1 && s.touch1_x >= TOUCH_SPLIT_X) || !as_select) begin
            b[BTN_OPTIONS] = 1'b1;
            b[BTN_TOUCH] = 1'b0;
         end
      end
      if (!as_select && b[BTN_TOUCH]) begin
         if ((!up0 && s.touch0_x <= TOUCH_SPLIT_X) ||
             (up0 && !up1 && s.touch1_x <= TOUCH_SPLIT_X) || !as_start) begin
            b[BTN_TOUCH] = 1'b0;
         end
      end
      if (cfg.mode[MODE_SHARE_SELECT] && b[BTN_SHARE]) begin
         b[BTN_TOUCH] = 1'b1;
         b[BTN_SHARE] = 1'b0;
      end

      r.buttons_out = b;
      r.left_trigger_out = 8'(lt);
      r.right_trigger_out = 8'(rt);
      r.left_x_out = 8'(lx);
      r.left_y_out = 8'(ly);
      r.right_x_out = 8'(rx);
      r.right_y_out = 8'(ry);
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic req_type make_sample(logic [15:0] b, logic [7:0] lt, logic [7:0] rt,
                                           logic [7:0] lx, logic [7:0] ly, logic [7:0] rx,
                                           logic [7:0] ry, logic [15:0] gx, logic [15:0] gz,
                                           logic [1:0] lifted, logic [11:0] t0,
                                           logic [11:0] t1);
      req_type s;
      s = '0;
      s.buttons_in = b;
      s.left_trigger_in = lt;
      s.right_trigger_in = rt;
      s.left_x_in = lx;
      s.left_y_in = ly;
      s.right_x_in = rx;
      s.right_y_in = ry;
      s.gyro_x = gx;
      s.gyro_z = gz;
      s.touch_lifted = lifted;
      s.touch0_x = t0;
      s.touch1_x = t1;
      return s;
   endfunction

   function automatic logic [7:0] near_value(int base, int reach);
      int v;
      v = base + int'($urandom_range(0, 2 * reach)) - reach;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   function automatic logic [15:0] pick_gyro(int lim);
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'(int'($urandom_range(0, 2 * lim)) - lim);
         2: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         default: return 16'(int'($urandom_range(0, 64)) - 32);
      endcase
   endfunction

   // Bias fields toward thresholds, deadzone edges, the gyro window and the touch split
   function automatic req_type random_sample();
      req_type s;
      int      lim;
      s = '0;
      s.buttons_in = 16'($urandom);
      if ($urandom_range(0, 2) != 0) s.buttons_in |= cfg.hotkey;
      s.left_trigger_in = $urandom_range(0, 1) ? 8'($urandom) : near_value(cfg.lt_threshold, 2);
      s.right_trigger_in = $urandom_range(0, 1) ? 8'($urandom) : near_value(cfg.rt_threshold, 2);
      if ($urandom_range(0, 1)) begin
         s.left_x_in = near_value(STICK_CENTRE, cfg.ls_deadzone + 3);
         s.left_y_in = near_value(STICK_CENTRE, cfg.ls_deadzone + 3);
      end else begin
         s.left_x_in = 8'($urandom);
         s.left_y_in = 8'($urandom);
      end
      case ($urandom_range(0, 2))
         0: begin
            s.right_x_in = 8'($urandom);
            s.right_y_in = 8'($urandom);
         end
         1: begin
            s.right_x_in = near_value(STICK_CENTRE, cfg.rs_deadzone + 3);
            s.right_y_in = near_value(STICK_CENTRE, cfg.rs_deadzone + 3);
         end
         default: begin
            s.right_x_in = near_value(STICK_CENTRE, GYRO_REACH + 10);
            s.right_y_in = near_value(STICK_CENTRE, GYRO_REACH + 10);
         end
      endcase
      // keep many products inside the clamp so the scaling itself is exercised
      lim = (cfg.sens == 0) ? 32767 : 256000 / cfg.sens + 8;
      if (lim > 32767) lim = 32767;
      s.gyro_x = pick_gyro(lim);
      s.gyro_z = pick_gyro(lim);
      s.touch_lifted = 2'($urandom);
      s.touch0_x = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(990, 1010));
      s.touch1_x = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(990, 1010));
      return s;
   endfunction

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_LT_THRESHOLD:  cfg.lt_threshold = value[7:0];
         CSR_RT_THRESHOLD:  cfg.rt_threshold = value[7:0];
         CSR_LS_DEADZONE:   cfg.ls_deadzone = value[7:0];
         CSR_RS_DEADZONE:   cfg.rs_deadzone = value[7:0];
         CSR_GYRO_DEADZONE: cfg.gyro_deadzone = value[7:0];
         CSR_GYRO_SENS:     cfg.sens = value;
         CSR_GYRO_HOTKEY:   cfg.hotkey = value;
         CSR_MODE_FLAGS:    cfg.mode = value[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic load_settings(logic [15:0] vals[8]);
      for (int i = 0; i < 8; i++) write_csr(csr_index_type'(i), vals[i]);
      settings_count++;
   endtask

   // Hold until every item has been accepted and answered, then let the pipe settle
   task automatic wait_drained();
      while (pending_samples.size() != 0 || expected_conditioned.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_phase_settings(int phase);
      logic [15:0] vals[8];
      if (phase == 1) begin
         foreach (vals[i]) vals[i] = 16'hFFFF;
      end else if (phase == 6) begin
         foreach (vals[i]) vals[i] = 16'h0000;
      end else begin
         // upper bits of narrow registers carry junk that must be dropped
         vals[CSR_LT_THRESHOLD] = 16'($urandom);
         vals[CSR_RT_THRESHOLD] = 16'($urandom);
         vals[CSR_LS_DEADZONE] = {8'($urandom),
            $urandom_range(0, 3) ? 8'($urandom_range(0, 60)) : 8'($urandom)};
         vals[CSR_RS_DEADZONE] = {8'($urandom),
            $urandom_range(0, 3) ? 8'($urandom_range(0, 60)) : 8'($urandom)};
         vals[CSR_GYRO_DEADZONE] = {8'($urandom), 8'($urandom_range(0, 70))};
         case ($urandom_range(0, 2))
            0: vals[CSR_GYRO_SENS] = 16'd256;
            1: vals[CSR_GYRO_SENS] = 16'($urandom_range(0, 1023));
            default: vals[CSR_GYRO_SENS] = 16'($urandom);
         endcase
         vals[CSR_GYRO_HOTKEY] = 16'($urandom & $urandom & $urandom);
         vals[CSR_MODE_FLAGS] = 16'($urandom);
         if ($urandom_range(0, 3) != 0) vals[CSR_MODE_FLAGS][MODE_GYRO_STICK] = 1'b1;
      end
      load_settings(vals);
   endtask

   // ---------------------------------------------------------------- driver and monitor

   always @(negedge clock) begin
      bit was_taken;
      was_taken = item_taken;
      if (was_taken) begin
         void'(pending_samples.pop_front());
         item_taken = 1'b0;
      end
      // hold an offered item until it is taken
      if (was_taken || !req_tvalid) begin
         if (!reset && pending_samples.size() != 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_samples[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result %0d %s mismatch, expected %0d, got %0d",
                     $time, results_seen, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_conditioned.push_back(condition_sample(req_tdata));
            item_taken = 1'b1;
            items_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_conditioned.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with no item outstanding, expected none, got %h",
                        $time, got);
            end else begin
               want = expected_conditioned.pop_front();
               check_field("buttons_out", want.buttons_out, got.buttons_out);
               check_field("left_trigger_out", want.left_trigger_out, got.left_trigger_out);
               check_field("right_trigger_out", want.right_trigger_out, got.right_trigger_out);
               check_field("left_x_out", want.left_x_out, got.left_x_out);
               check_field("left_y_out", want.left_y_out, got.left_y_out);
               check_field("right_x_out", want.right_x_out, got.right_x_out);
               check_field("right_y_out", want.right_y_out, got.right_y_out);
            end
            results_seen++;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      cfg.lt_threshold = '0;
      cfg.rt_threshold = '0;
      cfg.ls_deadzone = '0;
      cfg.rs_deadzone = '0;
      cfg.gyro_deadzone = '0;
      cfg.sens = GYRO_SENS_RESET;
      cfg.hotkey = '0;
      cfg.mode = '0;
      send_idle_pct = 37;
      recv_idle_pct = 49;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults: field extremes
      pending_samples.push_back(make_sample(16'h0000, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                            16'h0000, 16'h0000, 2'd0, 12'd0, 12'd0));
      pending_samples.push_back(make_sample(16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                            8'd255, 16'h7FFF, 16'h7FFF, 2'd3, 12'd4095,
                                            12'd4095));
      pending_samples.push_back(make_sample(SHARE_MASK | TOUCH_MASK, 8'd1, 8'd0, 8'd128,
                                            8'd128, 8'd128, 8'd128, 16'h8000, 16'h8000, 2'd0,
                                            12'd1000, 12'd0));
      wait_drained();

      // every mode on: threshold edges, deadzone edge, gyro window, touch split, share
      write_csr(CSR_LT_THRESHOLD, 16'd100);
      write_csr(CSR_RT_THRESHOLD, 16'd255);
      write_csr(CSR_LS_DEADZONE, 16'd5);
      write_csr(CSR_RS_DEADZONE, 16'd0);
      write_csr(CSR_GYRO_DEADZONE, 16'd0);
      write_csr(CSR_GYRO_SENS, 16'd256);
      write_csr(CSR_GYRO_HOTKEY, 16'd0);
      write_csr(CSR_MODE_FLAGS, ALL_MODES);
      settings_count++;
      pending_samples.push_back(make_sample(16'h0000, 8'd99, 8'd254, 8'd128, 8'd128, 8'd128,
                                            8'd128, 16'd0, 16'd0, 2'd0, 12'd0, 12'd0));
      pending_samples.push_back(make_sample(16'h0000, 8'd100, 8'd255, 8'd0, 8'd255, 8'd250,
                                            8'd5, 16'd0, 16'd0, 2'd0, 12'd0, 12'd0));
      pending_samples.push_back(make_sample(16'h0000, 8'd0, 8'd0, 8'd131, 8'd132, 8'd128,
                                            8'd128, 16'd1000, -16'sd1000, 2'd0, 12'd0, 12'd0));
      pending_samples.push_back(make_sample(16'h0000, 8'd0, 8'd0, 8'd131, 8'd133, 8'd208,
                                            8'd48, 16'd0, 16'd0, 2'd0, 12'd0, 12'd0));
      pending_samples.push_back(make_sample(16'h0000, 8'd0, 8'd0, 8'd128, 8'd128, 8'd209,
                                            8'd128, 16'd300, 16'd300, 2'd0, 12'd0, 12'd0));
      pending_samples.push_back(make_sample(TOUCH_MASK, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128,
                                            8'd128, 16'd0, 16'd0, 2'd0, 12'd1000, 12'd0));
      pending_samples.push_back(make_sample(TOUCH_MASK, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128,
                                            8'd128, 16'd0, 16'd0, 2'd0, 12'd999, 12'd4095));
      pending_samples.push_back(make_sample(TOUCH_MASK, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128,
                                            8'd128, 16'd0, 16'd0, 2'd1, 12'd0, 12'd1000));
      pending_samples.push_back(make_sample(TOUCH_MASK, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128,
                                            8'd128, 16'd0, 16'd0, 2'd3, 12'd2000, 12'd2000));
      pending_samples.push_back(make_sample(SHARE_MASK, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128,
                                            8'd128, 16'd0, 16'd0, 2'd0, 12'd0, 12'd0));
      pending_samples.push_back(make_sample(16'h0000, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128,
                                            8'd128, 16'h7FFF, 16'h8000, 2'd0, 12'd0, 12'd0));
      wait_drained();

      // full gain and a hotkey: clamped gyro, gyro deadzone, touch always start
      write_csr(CSR_LT_THRESHOLD, 16'd0);
      write_csr(CSR_RT_THRESHOLD, 16'd0);
      write_csr(CSR_LS_DEADZONE, 16'd255);
      write_csr(CSR_RS_DEADZONE, 16'd20);
      write_csr(CSR_GYRO_DEADZONE, 16'd40);
      write_csr(CSR_GYRO_SENS, 16'hFFFF);
      write_csr(CSR_GYRO_HOTKEY, HOTKEY_BIT);
      write_csr(CSR_MODE_FLAGS, (16'd1 << MODE_GYRO_STICK) | (16'd1 << MODE_TOUCH_START));
      settings_count++;
      pending_samples.push_back(make_sample(HOTKEY_BIT | TOUCH_MASK, 8'd0, 8'd0, 8'd128,
                                            8'd128, 8'd149, 8'd128, 16'd4, -16'sd4, 2'd0,
                                            12'd10, 12'd0));
      pending_samples.push_back(make_sample(TOUCH_MASK, 8'd0, 8'd0, 8'd255, 8'd255, 8'd148,
                                            8'd128, 16'd4, 16'd4, 2'd0, 12'd10, 12'd0));
      pending_samples.push_back(make_sample(HOTKEY_BIT, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128,
                                            8'd128, 16'd0, 16'd0, 2'd0, 12'd0, 12'd0));
      pending_samples.push_back(make_sample(HOTKEY_BIT, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128,
                                            8'd128, 16'd1, -16'sd1, 2'd0, 12'd0, 12'd0));
      wait_drained();

      // touch as select with share remap and digital triggers
      write_csr(CSR_MODE_FLAGS, (16'd1 << MODE_TRIG_BUTTONS) | (16'd1 << MODE_TOUCH_SELECT) |
                                (16'd1 << MODE_SHARE_SELECT));
      settings_count++;
      pending_samples.push_back(make_sample(TOUCH_MASK | SHARE_MASK, 8'd0, 8'd0, 8'd128,
                                            8'd128, 8'd128, 8'd128, 16'd0, 16'd0, 2'd0,
                                            12'd2000, 12'd0));
      pending_samples.push_back(make_sample(16'h0000, 8'd1, 8'd0, 8'd128, 8'd128, 8'd128,
                                            8'd128, 16'd0, 16'd0, 2'd0, 12'd0, 12'd0));
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 3) begin
            send_idle_pct = 37;
            recv_idle_pct = 49;
         end else if (phase < 6) begin
            send_idle_pct = 49;
            recv_idle_pct = 37;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         load_phase_settings(phase);
         // stall the output long enough for the pipe to back up into the input
         if (phase == 0 || phase == 4 || phase == 7) begin
            @(posedge clock);
            rsp_hold_cycles = 120;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) pending_samples.push_back(random_sample());
         wait_drained();
      end

      $display("Sent %0d gamepad samples, checked %0d results over %0d register settings,",
               items_sent, results_seen, settings_count);
      $display("with sender gaps, receiver stalls and long output holds.");
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
